// ===== rtl/core/lfu_pkg.sv =====
// lfu_pkg: shared constants, types and codes for the lfu cache replacement block
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package lfu_pkg;

    // table geometry
    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int USE_BITS = 16;
    localparam int STAMP_W  = 48;

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0]    CAP_RESET = 5'd16;
    localparam logic [USE_BITS-1:0] USE_MAX   = {USE_BITS{1'b1}};

    // request kinds
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the request and clear the scan results
        logic step;    // examine one table entry
        logic commit;  // write back and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // last entry is being examined
        logic out_stall;  // result register full and not taken
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/lfu_ctrl.sv =====
// lfu_ctrl: request sequencer (idle, table scan, write back)
// depends on lfu_pkg
`default_nettype none

module lfu_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  lfu_pkg::t_status  i_status,
    output lfu_pkg::t_cmd     o_cmd
);
    import lfu_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!i_status.out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = !i_status.out_stall;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lfu_datapath.sv =====
// lfu_datapath: entry table, sequential scan for match / victim / free slot,
// write back and result register; depends on lfu_pkg
`default_nettype none

module lfu_datapath (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  lfu_pkg::t_cmd              i_cmd,
    output lfu_pkg::t_status           o_status,
    input  wire [lfu_pkg::CAP_W-1:0]   i_capacity,
    input  wire                        i_mode,
    input  wire [lfu_pkg::KEY_W-1:0]   i_key,
    input  wire [lfu_pkg::VAL_W-1:0]   i_value,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic                       o_hit,
    output logic [lfu_pkg::VAL_W-1:0]  o_read_value,
    output logic                       o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]  o_evicted_key
);
    import lfu_pkg::*;

    // entry table
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_W-1:0]    r_key_mem   [ENTRIES];
    logic [VAL_W-1:0]    r_data_mem  [ENTRIES];
    logic [USE_BITS-1:0] r_uses_mem  [ENTRIES];
    logic [STAMP_W-1:0]  r_stamp_mem [ENTRIES];
    logic [STAMP_W-1:0]  r_clock;

    // captured request
    logic             r_mode;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // scan state
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_count;
    logic                r_found_v;
    logic [IDX_W-1:0]    r_found_idx;
    logic [VAL_W-1:0]    r_found_data;
    logic [USE_BITS-1:0] r_found_uses;
    logic                r_vic_v;
    logic [IDX_W-1:0]    r_vic_idx;
    logic [KEY_W-1:0]    r_vic_key;
    logic [USE_BITS-1:0] r_vic_uses;
    logic [STAMP_W-1:0]  r_vic_stamp;
    logic                r_free_v;
    logic [IDX_W-1:0]    r_free_idx;

    // result register
    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_rdata;
    logic             r_out_ev;
    logic [KEY_W-1:0] r_out_evkey;

    // registered table read, fetched one entry ahead of the scan pointer
    logic [IDX_W-1:0]    rd_idx;
    logic [KEY_W-1:0]    r_cur_key;
    logic [VAL_W-1:0]    r_cur_data;
    logic [USE_BITS-1:0] r_cur_uses;
    logic [STAMP_W-1:0]  r_cur_stamp;

    // current entry under the scan pointer
    logic                cur_v;
    logic [KEY_W-1:0]    cur_key;
    logic [USE_BITS-1:0] cur_uses;
    logic [STAMP_W-1:0]  cur_stamp;
    logic                better;

    assign rd_idx = i_cmd.load ? '0 : r_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.step) begin
            r_cur_key   <= r_key_mem[rd_idx];
            r_cur_data  <= r_data_mem[rd_idx];
            r_cur_uses  <= r_uses_mem[rd_idx];
            r_cur_stamp <= r_stamp_mem[rd_idx];
        end
    end

    assign cur_v     = r_valid[r_idx];
    assign cur_key   = r_cur_key;
    assign cur_uses  = r_cur_uses;
    assign cur_stamp = r_cur_stamp;
    assign better    = !r_vic_v || (cur_uses < r_vic_uses) ||
                       ((cur_uses == r_vic_uses) && (cur_stamp < r_vic_stamp));

    // write-back decision
    logic                full;
    logic                cap_zero;
    logic                do_evict;
    logic                wr_en;
    logic                wr_new;
    logic                wr_data_only;
    logic [IDX_W-1:0]    wr_idx;
    logic [USE_BITS-1:0] wr_uses;

    assign full     = (32'(r_count) >= 32'(ENTRIES));
    assign cap_zero = (i_capacity == '0);

    always_comb begin
        do_evict     = 1'b0;
        wr_en        = 1'b0;
        wr_new       = 1'b0;
        wr_data_only = 1'b0;
        wr_idx       = r_found_idx;
        wr_uses      = (r_found_uses == USE_MAX) ? USE_MAX
                                                 : r_found_uses + USE_BITS'(1);
        if (r_mode == MODE_GET) begin
            wr_en = r_found_v;
        end else if (!cap_zero) begin
            if (r_found_v) begin
                wr_en        = 1'b1;
                wr_data_only = 1'b1;
            end else begin
                do_evict = r_vic_v && (full || (32'(r_count) >= 32'(i_capacity)));
                wr_en    = do_evict || r_free_v;
                wr_new   = 1'b1;
                wr_idx   = do_evict ? r_vic_idx : r_free_idx;
                wr_uses  = USE_BITS'(1);
            end
        end
    end

    // status to controller
    assign o_status.scan_done = i_cmd.step && (r_idx == IDX_W'(ENTRIES - 1));
    assign o_status.out_stall = r_out_valid && !i_out_ready;

    // request capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_key     <= i_key;
            r_val     <= i_value;
            r_idx     <= '0;
            r_count   <= '0;
            r_found_v <= 1'b0;
            r_vic_v   <= 1'b0;
            r_free_v  <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (!cur_v) begin
                if (!r_free_v) begin
                    r_free_v   <= 1'b1;
                    r_free_idx <= r_idx;
                end
            end else begin
                r_count <= r_count + CNT_W'(1);
                if (!r_found_v && (cur_key == r_key)) begin
                    r_found_v    <= 1'b1;
                    r_found_idx  <= r_idx;
                    r_found_data <= r_cur_data;
                    r_found_uses <= cur_uses;
                end
                if (better) begin
                    r_vic_v     <= 1'b1;
                    r_vic_idx   <= r_idx;
                    r_vic_key   <= cur_key;
                    r_vic_uses  <= cur_uses;
                    r_vic_stamp <= cur_stamp;
                end
            end
        end
    end

    // table write back and access clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
        end else if (i_cmd.commit && wr_en) begin
            r_valid[wr_idx] <= 1'b1;
            r_clock         <= r_clock + STAMP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_uses_mem[wr_idx]  <= wr_uses;
            r_stamp_mem[wr_idx] <= r_clock;
            if (wr_new) begin
                r_key_mem[wr_idx] <= r_key;
            end
            if (wr_new || wr_data_only) begin
                r_data_mem[wr_idx] <= r_val;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit   <= r_found_v;
            r_out_rdata <= ((r_mode == MODE_GET) && r_found_v) ? r_found_data : '0;
            r_out_ev    <= do_evict;
            r_out_evkey <= do_evict ? r_vic_key : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_rdata;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_evkey;

endmodule

`default_nettype wire

// ===== rtl/core/lfu_cache_replacement_top.sv =====
// LFU key-value cache with least-recently-used tie-break.
// Input stream: one beat per request. tuser carries the mode (get or put),
// tdata carries key in bits [31:0] and value in bits [62:32].
// Output stream: exactly one beat per request. tuser bit 0 is hit, bit 1 is
// evicted; tdata carries read_value in bits [30:0], evicted_key in [62:31].
// APB register at byte address 0: capacity_in_use (5 bits, reset 16); write
// it only while no request is in flight.
// Each request walks the 16-entry table one entry per cycle, looking for the
// key, the least-used / oldest victim and the first free slot, then writes
// back. A new request is accepted only after the previous one has written
// back; the table is scanned through a single-entry read port.
// The result register frees the input side: the next request is accepted
// while a result still waits. If the receiver stalls, the next request halts
// in its write-back cycle until the result register drains.
// Reset empties the table (valid bits clear at once, no clearing pass),
// zeroes the access clock and sets the capacity to 16.
// depends on lfu_pkg, lfu_ctrl, lfu_datapath
`default_nettype none

module lfu_cache_replacement_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // key[31:0], value[62:32], zero pad
    input  wire  [0:0]  s_axis_tuser,   // mode[0]
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // read_value[30:0], evicted_key[62:31], zero pad
    output logic [1:0]  m_axis_tuser,   // hit[0], evicted[1]
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfu_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_sel;

    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    // configuration register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = cfg_sel ? 32'(r_capacity) : '0;

    // sequencer
    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // table and result register
    lfu_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_capacity    (r_capacity),
        .i_mode        (s_axis_tuser[0]),
        .i_key         (s_axis_tdata[KEY_W-1:0]),
        .i_value       (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_hit         (hit),
        .o_read_value  (read_value),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key)
    );

    // result beat packing
    assign m_axis_tuser = {evicted, hit};
    assign m_axis_tdata = {1'b0, evicted_key, read_value};

endmodule

`default_nettype wire
